>>> rtl/pgms_pkg.sv
// Shared types, constants and key-position codes for the pallet grab sequencer.
package pgms_pkg;

    localparam int HIST_DEPTH     = 10;
    localparam int HIST_IDX_W     = $clog2(HIST_DEPTH);
    localparam int HIST_CNT_W     = $clog2(HIST_DEPTH + 1);
    localparam int CORNER_Z_EXTRA = 2000;
    localparam logic [15:0] MARGIN_RESET = 16'd50;

    localparam int KEY_COUNT = 7;
    localparam logic [2:0] KP_WORK       = 3'd0;
    localparam logic [2:0] KP_STACK_UP   = 3'd1;
    localparam logic [2:0] KP_STACK_DOWN = 3'd2;
    localparam logic [2:0] KP_A_UP       = 3'd3;
    localparam logic [2:0] KP_A_DOWN     = 3'd4;
    localparam logic [2:0] KP_B_UP       = 3'd5;
    localparam logic [2:0] KP_B_DOWN     = 3'd6;
    localparam logic [2:0] REG_MARGIN    = 3'd7;

    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_HALF  = 2'd2;
    localparam logic [1:0] CMD_CLOSE = 2'd3;

    localparam logic [1:0] INNER_CLOSED = 2'd1;
    localparam logic [1:0] FINGER_CLOSED = 2'd2;
    localparam logic [1:0] CLAW_DONE    = 2'd1;

    localparam logic [3:0] SQ_START      = 4'd0;
    localparam logic [3:0] SQ_AT_WORK    = 4'd1;
    localparam logic [3:0] SQ_GRIP       = 4'd2;
    localparam logic [3:0] SQ_CLAW_OPEN  = 4'd3;
    localparam logic [3:0] SQ_STACK_UP   = 4'd4;
    localparam logic [3:0] SQ_STACK_DOWN = 4'd5;
    localparam logic [3:0] SQ_CLAW_HALF  = 4'd6;
    localparam logic [3:0] SQ_LIFT       = 4'd7;
    localparam logic [3:0] SQ_DEST_UP    = 4'd8;
    localparam logic [3:0] SQ_CORNER     = 4'd9;
    localparam logic [3:0] SQ_DEST_DOWN  = 4'd10;
    localparam logic [3:0] SQ_RELEASE    = 4'd11;
    localparam logic [3:0] SQ_RETRACT    = 4'd12;
    localparam logic [3:0] SQ_CLAW_CLOSE = 4'd13;
    localparam logic [3:0] SQ_HOME       = 4'd14;
    localparam logic [3:0] SQ_BAD        = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIST,
        ST_DECIDE,
        ST_ARRIVE,
        ST_ACT,
        ST_MOVE
    } seq_state_t;

    typedef struct packed {
        logic done;
        logic same;
    } hist_status_t;

endpackage

>>> rtl/pgms_hist.sv
// X reading history: shift-in on push, then one entry compared per cycle.
module pgms_hist
    import pgms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        x_value,
    output hist_status_t       status
);

    logic [31:0]           hist_reg [HIST_DEPTH];
    logic [31:0]           x_reg;
    logic [HIST_CNT_W-1:0] fill_reg;
    logic [HIST_CNT_W-1:0] idx_reg;
    logic                  busy_reg;
    logic                  same_reg;
    logic                  at_end;

    assign at_end = idx_reg >= fill_reg;
    assign status.done = busy_reg && at_end;
    assign status.same = same_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hist_reg[0] <= x_value;
            for (int i = 1; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
            x_reg <= x_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            same_reg <= 1'b0;
        end
        else if (start)
        begin
            if (fill_reg < HIST_CNT_W'(HIST_DEPTH))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            // entry 0 is the new reading itself
            idx_reg  <= HIST_CNT_W'(1);
            busy_reg <= 1'b1;
            same_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (at_end)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                if (hist_reg[idx_reg[HIST_IDX_W-1:0]] != x_reg)
                begin
                    same_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= HIST_CNT_W'(HIST_DEPTH))
        else $error("history fill beyond depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= fill_reg)
        else $error("history index past fill");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        status.done && !start |=> !busy_reg)
        else $error("history compare did not finish");

endmodule

>>> rtl/pallet_grab_motion_sequencer_unit.sv
// Pallet grab motion sequencer: origin calibration and fifteen-step grab sequence.
//
// One transfer in per control tick, one transfer out with the held setpoints,
// commands, busy, calibrated and step. A tick may run a history compare of up to
// nine entries when all zero switches are set (one entry per cycle), an arrival
// check over the four axes and a new setpoint set for the four axes, both
// through a single shared 35-bit adder/compare that handles one axis per cycle.
// The block takes the next tick only after the current result has been taken.
// Configuration writes go straight to the key-position and margin registers.
module pallet_grab_motion_sequencer_unit
    import pgms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] pos_w,
    input  logic [3:0]         zero_switches,
    input  logic [1:0]         inner_finger_state,
    input  logic [1:0]         finger_state,
    input  logic [1:0]         claw_state,
    input  logic               z_stop,
    input  logic               pallet_select,
    input  logic               run,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] target_x,
    output logic signed [31:0] target_y,
    output logic signed [31:0] target_z,
    output logic signed [31:0] target_w,
    output logic [1:0]         finger_cmd,
    output logic [1:0]         claw_cmd,
    output logic               busy_res,
    output logic               calibrated,
    output logic [3:0]         step
);

    seq_state_t   state_reg, state_next;
    hist_status_t hist_status;

    logic [63:0] keypos_reg [KEY_COUNT];
    logic [15:0] margin_reg;

    logic [31:0] pos_reg [4];
    logic [31:0] origin_reg [4];
    logic [31:0] target_reg [4];
    logic [1:0]  inner_reg, fing_reg, claw_st_reg;
    logic        zstop_reg, to_b_reg, run_reg;

    logic [3:0]  step_reg;
    logic [1:0]  finger_reg, claw_reg;
    logic        busy_reg, cal_reg, out_valid_reg;
    logic [2:0]  key_sel_reg;
    logic [1:0]  axis_reg;
    logic        extra_reg, arr_ok_reg;

    logic        accept, hist_start, seq_go;
    logic [2:0]  dest_up, dest_down, arr_key, mv_key;
    logic        need_arrive, cond, do_move, mv_extra;
    logic [3:0]  step_new;
    logic [1:0]  finger_new, claw_new;
    logic        busy_new;

    logic [63:0]        key_word;
    logic [15:0]        key16;
    logic signed [34:0] key_ext, org_ext, pos_ext, extra_ext, unit_sum, m_ext;
    logic               axis_ok;

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept   = in_valid && in_ready;
    assign hist_start = accept && (zero_switches == 4'hF);
    assign seq_go   = run_reg && cal_reg;

    pgms_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (hist_start),
        .x_value (pos_x),
        .status  (hist_status)
    );

    // shared axis unit: key + origin - pos for arrival, key + origin (+ z extra) for moves
    assign key_word  = keypos_reg[key_sel_reg];
    assign key16     = key_word[axis_reg*16 +: 16];
    assign key_ext   = {{19{key16[15]}}, key16};
    assign org_ext   = {{3{origin_reg[axis_reg][31]}}, origin_reg[axis_reg]};
    assign pos_ext   = {{3{pos_reg[axis_reg][31]}}, pos_reg[axis_reg]};
    assign extra_ext = (extra_reg && axis_reg == 2'd2) ? 35'(CORNER_Z_EXTRA) : '0;
    assign m_ext     = {19'd0, margin_reg};
    assign unit_sum  = key_ext + org_ext
                     + ((state_reg == ST_ARRIVE) ? -pos_ext : extra_ext);
    assign axis_ok   = (unit_sum <= m_ext) && (unit_sum >= -m_ext);

    assign dest_up   = to_b_reg ? KP_B_UP : KP_A_UP;
    assign dest_down = to_b_reg ? KP_B_DOWN : KP_A_DOWN;

    always_comb
    begin
        need_arrive = 1'b1;
        arr_key     = KP_WORK;
        case (step_reg)
            SQ_AT_WORK, SQ_HOME:       arr_key = KP_WORK;
            SQ_STACK_UP, SQ_LIFT:      arr_key = KP_STACK_UP;
            SQ_STACK_DOWN:             arr_key = KP_STACK_DOWN;
            SQ_DEST_UP, SQ_CORNER,
            SQ_RETRACT:                arr_key = dest_up;
            SQ_DEST_DOWN:              arr_key = dest_down;
            default:                   need_arrive = 1'b0;
        endcase
    end

    // sequence step decision, evaluated in ST_ACT
    always_comb
    begin
        cond       = 1'b0;
        do_move    = 1'b0;
        mv_key     = KP_WORK;
        mv_extra   = 1'b0;
        step_new   = step_reg;
        finger_new = finger_reg;
        claw_new   = claw_reg;
        busy_new   = 1'b1;
        case (step_reg)
            SQ_START:      begin cond = 1'b1; do_move = 1'b1; mv_key = KP_WORK;
                               finger_new = CMD_OPEN; end
            SQ_AT_WORK:    begin cond = arr_ok_reg; finger_new = cond ? CMD_CLOSE : finger_reg;
                           end
            SQ_GRIP:       begin
                               cond = inner_reg == INNER_CLOSED && fing_reg == FINGER_CLOSED;
                               claw_new = cond ? CMD_OPEN : claw_reg;
                           end
            SQ_CLAW_OPEN:  begin cond = claw_st_reg == CLAW_DONE; do_move = cond;
                               mv_key = KP_STACK_UP; end
            SQ_STACK_UP:   begin cond = arr_ok_reg; do_move = cond; mv_key = KP_STACK_DOWN; end
            SQ_STACK_DOWN: begin cond = arr_ok_reg || zstop_reg;
                               claw_new = cond ? CMD_HALF : claw_reg; end
            SQ_CLAW_HALF:  begin cond = claw_st_reg == CLAW_DONE; do_move = cond;
                               mv_key = KP_STACK_UP; end
            SQ_LIFT:       begin cond = arr_ok_reg; do_move = cond; mv_key = dest_up; end
            SQ_DEST_UP:    begin cond = arr_ok_reg; do_move = cond; mv_key = dest_down; end
            SQ_CORNER:     begin cond = arr_ok_reg; do_move = cond; mv_key = dest_down;
                               mv_extra = 1'b1; end
            SQ_DEST_DOWN:  begin cond = arr_ok_reg || zstop_reg;
                               claw_new = cond ? CMD_OPEN : claw_reg; end
            SQ_RELEASE:    begin cond = claw_st_reg == CLAW_DONE; do_move = cond;
                               mv_key = dest_up; end
            SQ_RETRACT:    begin cond = arr_ok_reg; claw_new = cond ? CMD_CLOSE : claw_reg; end
            SQ_CLAW_CLOSE: begin cond = claw_st_reg == CLAW_DONE; do_move = cond;
                               mv_key = KP_WORK; end
            SQ_HOME:       begin cond = arr_ok_reg; busy_new = !cond; end
            default:       begin cond = 1'b0; end
        endcase
        if (step_reg == SQ_BAD)
        begin
            step_new = SQ_START;
        end
        else if (cond)
        begin
            step_new = (step_reg == SQ_HOME) ? SQ_START : step_reg + 4'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = hist_start ? ST_HIST : ST_DECIDE;
            ST_HIST:   if (hist_status.done) state_next = ST_DECIDE;
            ST_DECIDE: state_next = !seq_go ? ST_IDLE : (need_arrive ? ST_ARRIVE : ST_ACT);
            ST_ARRIVE: if (axis_reg == 2'd3) state_next = ST_ACT;
            ST_ACT:    state_next = do_move ? ST_MOVE : ST_IDLE;
            ST_MOVE:   if (axis_reg == 2'd3) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg[0]  <= pos_x;
            pos_reg[1]  <= pos_y;
            pos_reg[2]  <= pos_z;
            pos_reg[3]  <= pos_w;
            inner_reg   <= inner_finger_state;
            fing_reg    <= finger_state;
            claw_st_reg <= claw_state;
            zstop_reg   <= z_stop;
            to_b_reg    <= pallet_select;
            run_reg     <= run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                keypos_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                origin_reg[i] <= '0;
                target_reg[i] <= '0;
            end
            margin_reg    <= MARGIN_RESET;
            step_reg      <= SQ_START;
            finger_reg    <= '0;
            claw_reg      <= '0;
            busy_reg      <= 1'b0;
            cal_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            key_sel_reg   <= KP_WORK;
            axis_reg      <= '0;
            extra_reg     <= 1'b0;
            arr_ok_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_MARGIN)
                begin
                    margin_reg <= cfg_data[15:0];
                end
                else
                begin
                    keypos_reg[cfg_index] <= cfg_data;
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_HIST:
                begin
                    if (hist_status.done && hist_status.same)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            origin_reg[i] <= pos_reg[i];
                        end
                        cal_reg <= 1'b1;
                    end
                end
                ST_DECIDE:
                begin
                    key_sel_reg <= arr_key;
                    axis_reg    <= '0;
                    arr_ok_reg  <= 1'b1;
                    if (!seq_go)
                    begin
                        busy_reg      <= step_reg != SQ_START;
                        out_valid_reg <= 1'b1;
                    end
                end
                ST_ARRIVE:
                begin
                    arr_ok_reg <= arr_ok_reg && axis_ok;
                    axis_reg   <= axis_reg + 2'd1;
                end
                ST_ACT:
                begin
                    step_reg    <= step_new;
                    finger_reg  <= finger_new;
                    claw_reg    <= claw_new;
                    busy_reg    <= busy_new;
                    key_sel_reg <= mv_key;
                    extra_reg   <= mv_extra;
                    axis_reg    <= '0;
                    if (!do_move)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                ST_MOVE:
                begin
                    target_reg[axis_reg] <= unit_sum[31:0];
                    axis_reg             <= axis_reg + 2'd1;
                    if (axis_reg == 2'd3)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign target_x   = target_reg[0];
    assign target_y   = target_reg[1];
    assign target_z   = target_reg[2];
    assign target_w   = target_reg[3];
    assign finger_cmd = finger_reg;
    assign claw_cmd   = claw_reg;
    assign busy_res   = busy_reg;
    assign calibrated = cal_reg;
    assign step       = step_reg;

    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_IDLE)
        else $error("result shown while sequencer working");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != SQ_BAD)
        else $error("sequence step out of range");

    a_act_needs_cal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACT |-> cal_reg && run_reg)
        else $error("sequence advanced without calibration or run");

    a_move_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MOVE && axis_reg == 2'd3 |=> out_valid_reg)
        else $error("move finished without a result");

endmodule
